[rtl/core/assert_macros.svh]
// assertion macros shared by the core rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// consequent follows the antecedent, delayed by the cyc argument
`define ASSERT_AFTER(label, ante, cyc, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##cyc (cons)) \
        else $error("latency check failed");

`endif

[rtl/core/ept_pkg.sv]
// types and constants for the pose to foot target core
// no dependencies
`timescale 1ns / 1ps

package ept_pkg;

    typedef struct packed {
        logic              leg_select;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] body_x;
        logic signed [15:0] body_y;
        logic signed [15:0] body_z;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] rot_r0c0;
        logic signed [15:0] rot_r0c1;
        logic signed [15:0] rot_r0c2;
        logic signed [15:0] rot_r1c0;
        logic signed [15:0] rot_r1c1;
        logic signed [15:0] rot_r1c2;
        logic signed [15:0] rot_r2c0;
        logic signed [15:0] rot_r2c1;
        logic signed [15:0] rot_r2c2;
        logic signed [15:0] foot_x;
        logic signed [15:0] foot_y;
        logic signed [15:0] foot_z;
    } target_t;

    localparam logic [2:0] REG_LEFT_X  = 3'd0;
    localparam logic [2:0] REG_LEFT_Y  = 3'd1;
    localparam logic [2:0] REG_LEFT_Z  = 3'd2;
    localparam logic [2:0] REG_RIGHT_X = 3'd3;
    localparam logic [2:0] REG_RIGHT_Y = 3'd4;
    localparam logic [2:0] REG_RIGHT_Z = 3'd5;

    localparam logic signed [15:0] LEFT_X_RST  = 16'sd606;
    localparam logic signed [15:0] LEFT_Y_RST  = -16'sd5597;
    localparam logic signed [15:0] LEFT_Z_RST  = 16'sd0;
    localparam logic signed [15:0] RIGHT_X_RST = -16'sd606;
    localparam logic signed [15:0] RIGHT_Y_RST = -16'sd5597;
    localparam logic signed [15:0] RIGHT_Z_RST = 16'sd0;

    // 4/pi in q15
    localparam logic signed [16:0] PHASE_GAIN = 17'sd41722;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    localparam logic [10:0] SIN_C5 = 11'd1160;
    localparam logic [13:0] SIN_C3 = 14'd10512;
    localparam logic [14:0] SIN_C1 = 15'd25736;

    localparam int unsigned LATENCY = 10;

    // q1.14 product, rounded half up
    function automatic logic signed [15:0] mul14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        logic signed [31:0] p;
        logic signed [32:0] w;
        p = a * b;
        w = 33'(p) + 33'sd8192;
        return w[29:14];
    endfunction

    function automatic logic signed [15:0] sat_ent(input logic signed [16:0] v);
        if (v > 17'sd16384)
            return ONE_Q14;
        else if (v < -17'sd16384)
            return -ONE_Q14;
        else
            return v[15:0];
    endfunction

endpackage

[rtl/core/euler_pose_to_foot_target_core.sv]
// pose to foot target core: rotation matrix and transformed foot offset
// depends on ept_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one pose beat per cycle whenever start is high; busy is always low.
// Each pose gives one result beat on result, marked by done, once it has
// passed through the ten register stages, which are: angle to phase,
// fold and square, three stages of the fifth order sine polynomial, the
// trig products, the nested products, the matrix sums with saturation, the
// offset products and the final sum with rounding. Offset registers are
// written through cfg_* at any time (cfg_ready stays high) and should only
// change while no pose is in flight.
module euler_pose_to_foot_target_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ept_pkg::pose_t   pose,
    output logic             done,
    output ept_pkg::target_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import ept_pkg::*;

    localparam int unsigned DLINE = 8;

    logic signed [15:0] off_reg [6];
    logic [LATENCY-1:0] v_reg;

    logic [15:0] ph_next [6];
    logic [15:0] ph_reg [6];
    logic signed [16:0] d_next [3];
    logic signed [16:0] d_reg [DLINE][3];

    logic [14:0] u_next [6];
    logic [14:0] u2_next [6];
    logic        neg_next [6];
    logic [14:0] u_s2_reg [6];
    logic [14:0] u2_s2_reg [6];
    logic        neg_s2_reg [6];

    logic [10:0] t1_next [6];
    logic [14:0] u_s3_reg [6];
    logic [14:0] u2_s3_reg [6];
    logic        neg_s3_reg [6];
    logic [10:0] t1_reg [6];

    logic [13:0] t3_next [6];
    logic [14:0] u_s4_reg [6];
    logic        neg_s4_reg [6];
    logic [13:0] t3_reg [6];

    logic signed [15:0] trig_next [6];
    logic signed [15:0] trig_reg [6];

    logic signed [15:0] srsp_reg, crsp_reg, cpcy_reg, crsy_reg, srsy_reg;
    logic signed [15:0] cpsy_reg, crcy_reg, srcy_reg, srcp_reg, crcp_reg;
    logic signed [15:0] sy6_reg, cy6_reg, sp6_reg;

    logic signed [15:0] q1_reg, q2_reg, q3_reg, q4_reg;
    logic signed [15:0] cpcy7_reg, crsy7_reg, srsy7_reg, cpsy7_reg, crcy7_reg;
    logic signed [15:0] srcy7_reg, srcp7_reg, crcp7_reg, sp7_reg;

    logic signed [15:0] r_next [9];
    logic signed [15:0] r_reg [9];
    logic signed [15:0] r9_reg [9];
    logic signed [32:0] pd_reg [9];

    logic signed [15:0] foot_next [3];
    target_t            result_next;
    target_t            result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = v_reg[LATENCY-1];
    assign result    = result_reg;

    // offset registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg[REG_LEFT_X]  <= LEFT_X_RST;
            off_reg[REG_LEFT_Y]  <= LEFT_Y_RST;
            off_reg[REG_LEFT_Z]  <= LEFT_Z_RST;
            off_reg[REG_RIGHT_X] <= RIGHT_X_RST;
            off_reg[REG_RIGHT_Y] <= RIGHT_Y_RST;
            off_reg[REG_RIGHT_Z] <= RIGHT_Z_RST;
        end
        else if (cfg_valid && cfg_index <= REG_RIGHT_Z)
        begin
            off_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[LATENCY-2:0], start};
    end

    // stage 1: angle to phase, offset minus body
    always_comb
    begin
        logic signed [15:0] ang [3];
        logic signed [32:0] prod;
        logic signed [33:0] sum;
        ang[0] = pose.roll_angle;
        ang[1] = pose.pitch_angle;
        ang[2] = pose.yaw_angle;
        for (int k = 0; k < 3; k++)
        begin
            prod = ang[k] * PHASE_GAIN;
            sum  = 34'(prod) + 34'sd16384;
            ph_next[2*k]   = sum[30:15];
            ph_next[2*k+1] = sum[30:15] + QUARTER_TURN;
        end
        if (pose.leg_select)
        begin
            d_next[0] = 17'(off_reg[REG_RIGHT_X]) - 17'(pose.body_x);
            d_next[1] = 17'(off_reg[REG_RIGHT_Y]) - 17'(pose.body_y);
            d_next[2] = 17'(off_reg[REG_RIGHT_Z]) - 17'(pose.body_z);
        end
        else
        begin
            d_next[0] = 17'(off_reg[REG_LEFT_X]) - 17'(pose.body_x);
            d_next[1] = 17'(off_reg[REG_LEFT_Y]) - 17'(pose.body_y);
            d_next[2] = 17'(off_reg[REG_LEFT_Z]) - 17'(pose.body_z);
        end
    end

    // stage 2: fold to a quarter turn and square
    always_comb
    begin
        logic signed [16:0] s;
        logic signed [16:0] f;
        logic signed [16:0] a;
        logic [29:0] sq;
        for (int k = 0; k < 6; k++)
        begin
            s = {ph_reg[k][15], ph_reg[k]};
            if (s > 17'sd16384)
                f = 17'sd32768 - s;
            else if (s < -17'sd16384)
                f = -17'sd32768 - s;
            else
                f = s;
            neg_next[k] = f[16];
            a = f[16] ? -f : f;
            u_next[k] = a[14:0];
            sq = u_next[k] * u_next[k];
            u2_next[k] = sq[28:14];
        end
    end

    // stage 3
    always_comb
    begin
        logic [25:0] m;
        for (int k = 0; k < 6; k++)
        begin
            m = u2_s2_reg[k] * SIN_C5;
            t1_next[k] = m[24:14];
        end
    end

    // stage 4
    always_comb
    begin
        logic [13:0] t2;
        logic [28:0] m;
        for (int k = 0; k < 6; k++)
        begin
            t2 = SIN_C3 - 14'(t1_reg[k]);
            m  = u2_s3_reg[k] * t2;
            t3_next[k] = m[27:14];
        end
    end

    // stage 5: sine value with sign
    always_comb
    begin
        logic [14:0] t4;
        logic [29:0] m;
        logic signed [15:0] y;
        for (int k = 0; k < 6; k++)
        begin
            t4 = SIN_C1 - 15'(t3_reg[k]);
            m  = u_s4_reg[k] * t4;
            y  = m[29:14];
            trig_next[k] = neg_s4_reg[k] ? -y : y;
        end
    end

    // stage 8: matrix sums, lanes are sr cr sp cp sy cy
    always_comb
    begin
        r_next[0] = sat_ent(17'(cpcy7_reg));
        r_next[1] = sat_ent(17'(q1_reg) - 17'(crsy7_reg));
        r_next[2] = sat_ent(17'(srsy7_reg) + 17'(q2_reg));
        r_next[3] = sat_ent(17'(cpsy7_reg));
        r_next[4] = sat_ent(17'(crcy7_reg) + 17'(q3_reg));
        r_next[5] = sat_ent(17'(q4_reg) - 17'(srcy7_reg));
        r_next[6] = sat_ent(-17'(sp7_reg));
        r_next[7] = sat_ent(17'(srcp7_reg));
        r_next[8] = sat_ent(17'(crcp7_reg));
    end

    // stage 10: foot sums, rounding and saturation
    always_comb
    begin
        logic signed [35:0] acc;
        logic signed [21:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            acc = 36'(pd_reg[i]) + 36'(pd_reg[3+i]) + 36'(pd_reg[6+i]) + 36'sd8192;
            sh  = acc[35:14];
            if (sh > 22'sd32767)
                foot_next[i] = 16'sh7fff;
            else if (sh < -22'sd32768)
                foot_next[i] = 16'sh8000;
            else
                foot_next[i] = sh[15:0];
        end
        result_next.rot_r0c0 = r9_reg[0];
        result_next.rot_r0c1 = r9_reg[3];
        result_next.rot_r0c2 = r9_reg[6];
        result_next.rot_r1c0 = r9_reg[1];
        result_next.rot_r1c1 = r9_reg[4];
        result_next.rot_r1c2 = r9_reg[7];
        result_next.rot_r2c0 = r9_reg[2];
        result_next.rot_r2c1 = r9_reg[5];
        result_next.rot_r2c2 = r9_reg[8];
        result_next.foot_x   = foot_next[0];
        result_next.foot_y   = foot_next[1];
        result_next.foot_z   = foot_next[2];
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        ph_reg   <= ph_next;
        d_reg[0] <= d_next;
        for (int s = 1; s < DLINE; s++)
            d_reg[s] <= d_reg[s-1];

        u_s2_reg   <= u_next;
        u2_s2_reg  <= u2_next;
        neg_s2_reg <= neg_next;

        u_s3_reg   <= u_s2_reg;
        u2_s3_reg  <= u2_s2_reg;
        neg_s3_reg <= neg_s2_reg;
        t1_reg     <= t1_next;

        u_s4_reg   <= u_s3_reg;
        neg_s4_reg <= neg_s3_reg;
        t3_reg     <= t3_next;

        trig_reg <= trig_next;

        srsp_reg <= mul14(trig_reg[0], trig_reg[2]);
        crsp_reg <= mul14(trig_reg[1], trig_reg[2]);
        cpcy_reg <= mul14(trig_reg[3], trig_reg[5]);
        crsy_reg <= mul14(trig_reg[1], trig_reg[4]);
        srsy_reg <= mul14(trig_reg[0], trig_reg[4]);
        cpsy_reg <= mul14(trig_reg[3], trig_reg[4]);
        crcy_reg <= mul14(trig_reg[1], trig_reg[5]);
        srcy_reg <= mul14(trig_reg[0], trig_reg[5]);
        srcp_reg <= mul14(trig_reg[0], trig_reg[3]);
        crcp_reg <= mul14(trig_reg[1], trig_reg[3]);
        sy6_reg  <= trig_reg[4];
        cy6_reg  <= trig_reg[5];
        sp6_reg  <= trig_reg[2];

        q1_reg    <= mul14(srsp_reg, cy6_reg);
        q2_reg    <= mul14(crsp_reg, cy6_reg);
        q3_reg    <= mul14(srsp_reg, sy6_reg);
        q4_reg    <= mul14(crsp_reg, sy6_reg);
        cpcy7_reg <= cpcy_reg;
        crsy7_reg <= crsy_reg;
        srsy7_reg <= srsy_reg;
        cpsy7_reg <= cpsy_reg;
        crcy7_reg <= crcy_reg;
        srcy7_reg <= srcy_reg;
        srcp7_reg <= srcp_reg;
        crcp7_reg <= crcp_reg;
        sp7_reg   <= sp6_reg;

        r_reg <= r_next;

        r9_reg <= r_reg;
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
                pd_reg[3*j+i] <= d_reg[DLINE-1][j] * r_reg[3*j+i];

        result_reg <= result_next;
    end

    `ASSERT_AFTER(a_latency, start, 10, done)
    `ASSERT_IMPLIES(a_r1c1_range, done, result.rot_r1c1 >= -ONE_Q14 && result.rot_r1c1 <= ONE_Q14)
    `ASSERT_IMPLIES(a_r2c0_range, done, result.rot_r2c0 >= -ONE_Q14 && result.rot_r2c0 <= ONE_Q14)

endmodule
